@@ hdl/gha_pkg.sv @@
// gha_pkg: shared constants for the generational handle allocator
// op codes, status codes, field widths and default sizing
// no dependencies
package gha_pkg;

  localparam int GHA_SLOTS    = 4096;
  localparam int GHA_GEN_BITS = 4;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 12;
  localparam int GEN_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd2;

endpackage

@@ hdl/gha_if.sv @@
// gha_req_if / gha_rsp_if: valid-ready channels for requests and results
// depends on gha_pkg for field widths
interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::OP_W-1:0]      op;
  logic [gha_pkg::SLOT_W-1:0]    handle_slot;
  logic [gha_pkg::GEN_W-1:0]     handle_generation;

  modport source (output valid, op, handle_slot, handle_generation, input ready);
  modport sink   (input valid, op, handle_slot, handle_generation, output ready);
endinterface

interface gha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::SLOT_W-1:0]    new_slot;
  logic [gha_pkg::GEN_W-1:0]     new_generation;
  logic                          is_live;

  modport source (output valid, status, new_slot, new_generation, is_live, input ready);
  modport sink   (input valid, status, new_slot, new_generation, is_live, output ready);
endinterface

@@ hdl/gha_slot_ram.sv @@
// gha_slot_ram: single-port-write, single-port-read synchronous slot table
// registered read data; no dependencies
module gha_slot_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/generational_handle_allocator.sv @@
// channel | dir | payload                                   | accepted when
// req     | in  | op, handle_slot, handle_generation        | req.valid && req.ready
// rsp     | out | status, new_slot, new_generation, is_live | rsp.valid && rsp.ready
//
// each item runs as the slot table read, then the read-modify-write of that
// entry, both through the single slot table memory, before the next item is taken.
// after reset the table reads as its initial contents at once: entries at or
// above the fill count are taken as never written, so no clearing pass runs.
// a finished result sits in the output register; the next item is taken while
// it waits, and a second result stalls in the write-back cycle until rsp frees.
// reset is synchronous, active high.
// depends on gha_pkg, gha_if, gha_slot_ram
module generational_handle_allocator #(
  parameter int SLOTS           = gha_pkg::GHA_SLOTS,
  parameter int GENERATION_BITS = gha_pkg::GHA_GEN_BITS
) (
  input logic      clk,
  input logic      rst,
  gha_req_if.sink  req,
  gha_rsp_if.source rsp
);

  import gha_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int GB = GENERATION_BITS;
  localparam int EW = SW + GB + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [GB-1:0] GEN_TOP   = {GB{1'b1}};
  localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // latched item
  logic [OP_W-1:0] op_q;
  logic [GB-1:0]   hgen_q;
  logic            in_range_q;
  logic [SW-1:0]   addr_q;

  logic [SW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] fill;          // slots below this have been written at least once

  // memory ports
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  // decoded entry
  logic          fresh;
  logic [SW-1:0] ent_next;
  logic [GB-1:0] ent_gen;
  logic          ent_act;
  logic          live;
  logic          commit;

  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [GEN_W-1:0]    gen_next;
  logic                is_live_next;

  gha_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_data (wr_data)
  );

  assign req.ready = (state == S_IDLE);
  assign rd_en     = req.valid && req.ready;
  assign rd_addr   = (req.op == OP_CREATE) ? free_head : SW'(req.handle_slot);

  assign commit = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  // never-written entries read as their reset contents
  always_comb begin
    fresh = (CW'(addr_q) >= fill);
    if (fresh) begin
      ent_next = (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;
      ent_gen  = '0;
      ent_act  = 1'b0;
    end else begin
      ent_next = rd_data[EW-1 -: SW];
      ent_gen  = rd_data[GB:1];
      ent_act  = rd_data[0];
    end
    live = in_range_q && ent_act && (ent_gen == hgen_q);
  end

  always_comb begin
    status_next  = ST_DONE;
    slot_next    = '0;
    gen_next     = '0;
    is_live_next = 1'b0;
    wr_en        = 1'b0;
    wr_data      = {ent_next, ent_gen, 1'b0};
    case (op_q)
      OP_CREATE: begin
        if (free_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          slot_next = SLOT_W'(addr_q);
          gen_next  = GEN_W'(ent_gen);
          wr_en     = commit;
          wr_data   = {ent_next, ent_gen, 1'b1};
        end
      end
      OP_DESTROY: begin
        if (!live) begin
          status_next = ST_NOT_LIVE;
        end else begin
          wr_en = commit;
          if (ent_gen != GEN_TOP) begin
            wr_data = {free_head, ent_gen + 1'b1, 1'b0};
          end
        end
      end
      OP_QUERY: begin
        is_live_next = live;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      free_count <= FULL_CNT;
      fill       <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !commit) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (rd_en) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state     <= S_IDLE;
            rsp.valid <= 1'b1;
            if (op_q == OP_CREATE && free_count != '0) begin
              free_head  <= ent_next;
              free_count <= free_count - 1'b1;
              if (fresh) begin
                fill <= fill + 1'b1;
              end
            end else if (op_q == OP_DESTROY && live && ent_gen != GEN_TOP) begin
              free_head  <= addr_q;
              free_count <= free_count + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_q       <= req.op;
      hgen_q     <= GB'(req.handle_generation);
      in_range_q <= (32'(req.handle_slot) < SLOTS);
      addr_q     <= rd_addr;
    end
    if (commit) begin
      rsp.status         <= status_next;
      rsp.new_slot       <= slot_next;
      rsp.new_generation <= gen_next;
      rsp.is_live        <= is_live_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FULL_CNT)
    else $error("free count above pool size");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count above pool size");

  a_fill_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill >= $past(fill))
    else $error("fill count went down");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == S_EXEC && !req.ready)
    else $error("accepted item did not enter write-back");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid && state == S_IDLE)
    else $error("write-back did not present a result");
`endif

endmodule
